/* rtl/sync_length_crc16_deframer_top_assert.svh */
// Assertion macros used by the deframer controller.
`ifndef SYNC_LENGTH_CRC16_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_LENGTH_CRC16_DEFRAMER_TOP_ASSERT_SVH
`ifndef SYNTH
// Clocked check, held off while reset is high.
`define SLCD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check, also active during reset.
`define SLCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLCD_ASSERT(lbl, clk, rst, prop, msg)
`define SLCD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/slcd_pkg.sv */
package slcd_pkg;

   // Window geometry
   localparam int WINDOW_BYTES = 14;
   localparam int WIN_IDX_W    = $clog2(WINDOW_BYTES);
   localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);

   // CRC-16/MODBUS
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Result queue depth
   localparam int RSP_DEPTH = 2;

   // Input operations
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_GOOD     = 2'd1;
   localparam logic [1:0] KIND_CRC_ERR  = 2'd2;
   localparam logic [1:0] KIND_OVERSIZE = 2'd3;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [15:0] command_code;
      logic [31:0] sequence_number;
      logic [15:0] payload_count;
      logic [15:0] tail_word;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_CRC,
      ST_CLOSE
   } st_type;

   typedef enum logic [1:0] {
      SEL_PAYLOAD,
      SEL_OVERSIZE,
      SEL_SHORT,
      SEL_STATUS
   } res_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        clear;
      logic        byte_hunt;
      logic        byte_frame;
      logic        rescan;
      logic        load_hdr;
      logic        crc_step;
      logic        close;
      logic        push;
      res_sel_type sel;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic in_frame;
      logic closing;
      logic fill_last;
      logic oversize;
      logic short_len;
      logic crc_done;
      logic total_is_win;
   } sts_type;

   // One byte through the reflected CRC, bit by bit
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i,
                                            input logic [7:0]  data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* rtl/slcd_rsp_fifo.sv */
module slcd_rsp_fifo
   import slcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_type           mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop;

   assign rsp_valid = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(RSP_DEPTH));
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/slcd_dp.sv */
module slcd_dp
   import slcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] sync_word,
   input  logic [16:0] max_frame_bytes,
   output sts_type     sts,
   output rsp_type     push_data
);

   logic [7:0]           win_ff [WINDOW_BYTES];
   logic [7:0]           win_in [WINDOW_BYTES];
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [16:0]          offset_ff, offset_in;
   logic [15:0]          length_ff, length_in;
   logic [15:0]          crc_ff, crc_in;
   logic [15:0]          cmd_ff, cmd_in;
   logic [31:0]          seq_ff, seq_in;
   logic [WIN_IDX_W-1:0] idx_ff, idx_in;
   logic [WIN_IDX_W-1:0] endm1_ff, endm1_in;

   logic [16:0]             hdr_total;
   logic [16:0]             frame_total;
   logic [WINDOW_BYTES-2:0] match;
   logic [WIN_IDX_W-1:0]    drop_n;
   logic                    rescan_hit;
   logic [WIN_IDX_W-1:0]    rescan_pos;
   logic [FILL_W-1:0]       rescan_fill;
   logic                    head_sync;
   logic                    crc_inc;
   logic                    closing;
   logic                    start_frame;
   logic [15:0]             stored_crc;
   logic                    shift;

   // Header and frame sizes
   assign hdr_total   = {1'b0, win_ff[2], win_ff[3]} + 17'd6;
   assign frame_total = {1'b0, length_ff} + 17'd6;
   assign closing     = ((offset_ff + 17'd1) == frame_total);
   assign crc_inc     = (({1'b0, offset_ff} + 18'd5) <= {1'b0, frame_total});
   assign head_sync   = ({win_ff[WINDOW_BYTES-1], rx_byte} == sync_word);
   assign start_frame = cmd.crc_step && sts.crc_done && !sts.total_is_win;
   assign shift       = cmd.byte_hunt || cmd.byte_frame;
   assign stored_crc  = {win_ff[10], win_ff[11]};

   // Status to the controller
   always_comb begin
      sts.in_frame     = (offset_ff != '0);
      sts.closing      = closing;
      sts.fill_last    = (fill_ff == FILL_W'(WINDOW_BYTES - 1));
      sts.oversize     = (hdr_total > max_frame_bytes);
      sts.short_len    = (hdr_total < 17'(WINDOW_BYTES));
      sts.crc_done     = (idx_ff == endm1_ff);
      sts.total_is_win = (frame_total == 17'(WINDOW_BYTES));
   end

   // Sync matches at every pair of the full window
   always_comb begin
      for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
         match[k] = ({win_ff[k], win_ff[k+1]} == sync_word);
      end
   end

   // Rescan: the window is right-aligned, so a match at k leaves 14-k bytes
   always_comb begin
      drop_n     = sts.oversize ? WIN_IDX_W'(1) : hdr_total[WIN_IDX_W-1:0];
      rescan_hit = 1'b0;
      rescan_pos = '0;
      for (int k = WINDOW_BYTES - 2; k >= 0; k--) begin
         if (match[k] && (WIN_IDX_W'(k) >= drop_n)) begin
            rescan_hit = 1'b1;
            rescan_pos = WIN_IDX_W'(k);
         end
      end
      rescan_fill = rescan_hit ? (FILL_W'(WINDOW_BYTES) - FILL_W'(rescan_pos))
                               : FILL_W'(1);
   end

   // Window shift line, newest byte at the top
   always_comb begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
         win_in[i] = shift ? win_ff[i+1] : win_ff[i];
      end
      win_in[WINDOW_BYTES-1] = shift ? rx_byte : win_ff[WINDOW_BYTES-1];
   end

   // Control registers of the frame
   always_comb begin
      fill_in   = fill_ff;
      offset_in = offset_ff;
      length_in = length_ff;
      crc_in    = crc_ff;
      cmd_in    = cmd_ff;
      seq_in    = seq_ff;
      idx_in    = idx_ff;
      endm1_in  = endm1_ff;
      if (cmd.clear || cmd.close) begin
         fill_in   = '0;
         offset_in = '0;
         crc_in    = CRC_INIT;
      end
      if (cmd.byte_hunt) begin
         if (fill_ff == '0) begin
            fill_in = FILL_W'(1);
         end else if (fill_ff == FILL_W'(1)) begin
            fill_in = head_sync ? FILL_W'(2) : FILL_W'(1);
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (cmd.byte_frame) begin
         if (crc_inc) begin
            crc_in = crc_byte(crc_ff, rx_byte);
         end
         if (!closing) begin
            offset_in = offset_ff + 17'd1;
         end
      end
      if (cmd.rescan) begin
         fill_in = rescan_fill;
      end
      if (cmd.load_hdr) begin
         length_in = {win_ff[2], win_ff[3]};
         cmd_in    = {win_ff[4], win_ff[5]};
         seq_in    = {win_ff[6], win_ff[7], win_ff[8], win_ff[9]};
         crc_in    = CRC_INIT;
         idx_in    = '0;
         // Last window byte covered by the header CRC pass
         endm1_in  = (hdr_total >= 17'(WINDOW_BYTES + 4)) ?
                     WIN_IDX_W'(WINDOW_BYTES - 1) :
                     (hdr_total[WIN_IDX_W-1:0] - WIN_IDX_W'(5));
      end
      if (cmd.crc_step) begin
         crc_in = crc_byte(crc_ff, win_ff[idx_ff]);
         idx_in = idx_ff + 1'b1;
      end
      if (start_frame) begin
         offset_in = 17'(WINDOW_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         offset_ff <= '0;
         length_ff <= '0;
         crc_ff    <= CRC_INIT;
         cmd_ff    <= '0;
         seq_ff    <= '0;
         idx_ff    <= '0;
         endm1_ff  <= '0;
      end else begin
         fill_ff   <= fill_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
         crc_ff    <= crc_in;
         cmd_ff    <= cmd_in;
         seq_ff    <= seq_in;
         idx_ff    <= idx_in;
         endm1_ff  <= endm1_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_BYTES; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   // Result assembly
   always_comb begin
      push_data = '0;
      unique case (cmd.sel)
         SEL_PAYLOAD: begin
            push_data.kind         = KIND_PAYLOAD;
            push_data.payload_byte = win_ff[10];
            push_data.last         = !closing;
         end
         SEL_OVERSIZE: begin
            push_data.kind = KIND_OVERSIZE;
            push_data.last = 1'b1;
         end
         SEL_SHORT: begin
            push_data.kind = KIND_CRC_ERR;
            push_data.last = 1'b1;
         end
         SEL_STATUS: begin
            push_data.last = 1'b1;
            if (stored_crc == crc_ff) begin
               push_data.kind            = KIND_GOOD;
               push_data.command_code    = cmd_ff;
               push_data.sequence_number = seq_ff;
               push_data.payload_count   = length_ff - 16'd8;
               push_data.tail_word       = {win_ff[12], win_ff[13]};
            end else begin
               push_data.kind = KIND_CRC_ERR;
            end
         end
         default: push_data = '0;
      endcase
   end

endmodule

/* rtl/slcd_ctrl.sv */
module slcd_ctrl
   import slcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    operation,
   output logic    req_ready,
   input  logic    rsp_full,
   input  sts_type sts,
   output cmd_type cmd
);

`include "sync_length_crc16_deframer_top_assert.svh"

   st_type state_ff, state_in;
   logic   accept;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.sel   = SEL_PAYLOAD;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_full;
            if (accept) begin
               if (operation == OP_CLEAR) begin
                  cmd.clear = 1'b1;
               end else if (sts.in_frame) begin
                  cmd.byte_frame = 1'b1;
                  cmd.push       = 1'b1;
                  cmd.sel        = SEL_PAYLOAD;
                  if (sts.closing) begin
                     state_in = ST_CLOSE;
                  end
               end else begin
                  cmd.byte_hunt = 1'b1;
                  if (sts.fill_last) begin
                     state_in = ST_DECIDE;
                  end
               end
            end
         end
         ST_DECIDE: begin
            if (sts.oversize || sts.short_len) begin
               if (!rsp_full) begin
                  cmd.push   = 1'b1;
                  cmd.sel    = sts.oversize ? SEL_OVERSIZE : SEL_SHORT;
                  cmd.rescan = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.load_hdr = 1'b1;
               state_in     = ST_CRC;
            end
         end
         ST_CRC: begin
            cmd.crc_step = 1'b1;
            if (sts.crc_done) begin
               state_in = sts.total_is_win ? ST_CLOSE : ST_IDLE;
            end
         end
         ST_CLOSE: begin
            if (!rsp_full) begin
               cmd.push  = 1'b1;
               cmd.sel   = SEL_STATUS;
               cmd.close = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `SLCD_ASSERT(a_push_room, clock, reset, cmd.push |-> !rsp_full, "result pushed into full queue")
   `SLCD_ASSERT(a_frame_start, clock, reset, (state_ff == ST_CRC && sts.crc_done && !sts.total_is_win) |=> (state_ff == ST_IDLE && sts.in_frame), "frame not opened after header CRC")
   `SLCD_ASSERT(a_close_ends, clock, reset, (state_ff == ST_CLOSE && !rsp_full) |=> !sts.in_frame, "frame still open after status")

endmodule

/* rtl/sync_length_crc16_deframer_top.sv */
// A payload result enters the result queue in the cycle of its byte transfer; the
// closing status is pushed from ST_CLOSE once the queue has room. Throughput: one
// byte per cycle while hunting and inside a frame, while the queue is not full; a
// full header window stalls input for ST_DECIDE and the byte-wide CRC (ST_CRC).
// Reset: synchronous, active high; clears control state, sync_word to 0 and
// max_frame_bytes to 4096; the window bytes are not cleared.
module sync_length_crc16_deframer_top
   import slcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic CSR_SYNC_WORD = 1'b0;
   localparam logic CSR_MAX_FRAME = 1'b1;

   logic [15:0] sync_ff, sync_in;
   logic [16:0] maxf_ff, maxf_in;
   logic        csr_wr;
   cmd_type     cmd;
   sts_type     sts;
   rsp_type     push_data;
   logic        rsp_full;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      sync_in    = sync_ff;
      maxf_in    = maxf_ff;
      csr_prdata = '0;
      unique case (csr_paddr[2])
         CSR_SYNC_WORD: begin
            csr_prdata = {16'd0, sync_ff};
            if (csr_wr) begin
               sync_in = csr_pwdata[15:0];
            end
         end
         CSR_MAX_FRAME: begin
            csr_prdata = {15'd0, maxf_ff};
            if (csr_wr) begin
               maxf_in = csr_pwdata[16:0];
            end
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= 16'd0;
         maxf_ff <= 17'd4096;
      end else begin
         sync_ff <= sync_in;
         maxf_ff <= maxf_in;
      end
   end

   slcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .operation (req_data.operation),
      .req_ready (req_ready),
      .rsp_full  (rsp_full),
      .sts       (sts),
      .cmd       (cmd)
   );

   slcd_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .rx_byte         (req_data.rx_byte),
      .sync_word       (sync_ff),
      .max_frame_bytes (maxf_ff),
      .sts             (sts),
      .push_data       (push_data)
   );

   slcd_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd.push),
      .push_data (push_data),
      .full      (rsp_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* bench/sync_length_crc16_deframer_top_test.sv */
`timescale 1ns / 1ps

import slcd_pkg::*;

// Tracks the deframer state and holds the results still owed by the block.
class deframer_scoreboard;
   logic [15:0] sync_word;
   logic [16:0] max_frame;
   logic [7:0]  win [WINDOW_BYTES];
   int          fill;
   int          offset;
   int          len;
   logic [15:0] crc;
   logic [15:0] cmd;
   logic [31:0] seq;
   rsp_type     pending [$];
   int          errors;
   int          results_seen;

   function new();
      sync_word = 16'h0000;
      max_frame = 17'd4096;
      fill = 0;
      offset = 0;
      len = 0;
      crc = CRC_INIT;
      cmd = '0;
      seq = '0;
      errors = 0;
      results_seen = 0;
   endfunction

   // Reflected CRC-16, one byte
   function logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
      logic [15:0] x;
      x = c ^ {8'h00, d};
      for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
      return x;
   endfunction

   function void shift(int n);
      for (int i = 0; i + n < WINDOW_BYTES; i++) win[i] = win[i + n];
   endfunction

   function void add(logic [1:0] kind, logic [7:0] pb, logic [15:0] c, logic [31:0] s,
                     logic [15:0] cnt, logic [15:0] tail, logic last);
      rsp_type r;
      r.kind = kind;
      r.payload_byte = pb;
      r.command_code = c;
      r.sequence_number = s;
      r.payload_count = cnt;
      r.tail_word = tail;
      r.last = last;
      pending.push_back(r);
   endfunction

   // Drop n leading bytes of a full window, then hunt through the rest
   function void drop_rescan(int n);
      int rem;
      rem = WINDOW_BYTES - n;
      shift(n);
      for (int i = 0; i + 1 < rem; i++) begin
         if ({win[i], win[i + 1]} == sync_word) begin
            shift(i);
            fill = rem - i;
            return;
         end
      end
      win[0] = win[rem - 1];
      fill = 1;
   endfunction

   function void close_frame();
      if ({win[10], win[11]} == crc)
         add(KIND_GOOD, 0, cmd, seq, 16'(len - 8), {win[12], win[13]}, 1'b1);
      else
         add(KIND_CRC_ERR, 0, 0, 0, 0, 0, 1'b1);
      offset = 0;
      fill = 0;
      crc = CRC_INIT;
   endfunction

   function void decide();
      int total, stop;
      len = {win[2], win[3]};
      total = len + 6;
      if (total > max_frame) begin
         add(KIND_OVERSIZE, 0, 0, 0, 0, 0, 1'b1);
         drop_rescan(1);
         return;
      end
      if (total < WINDOW_BYTES) begin
         add(KIND_CRC_ERR, 0, 0, 0, 0, 0, 1'b1);
         drop_rescan(total);
         return;
      end
      cmd = {win[4], win[5]};
      seq = {win[6], win[7], win[8], win[9]};
      stop = (total - 4 > WINDOW_BYTES) ? WINDOW_BYTES : total - 4;
      crc = CRC_INIT;
      for (int i = 0; i < stop; i++) crc = crc_step(crc, win[i]);
      if (total == WINDOW_BYTES) close_frame();
      else offset = WINDOW_BYTES;
   endfunction

   // Accepted request transfer
   function void note_request(req_type r);
      int total;
      if (r.operation == OP_CLEAR) begin
         fill = 0;
         offset = 0;
         crc = CRC_INIT;
         return;
      end
      if (offset != 0) begin
         total = len + 6;
         shift(1);
         win[WINDOW_BYTES - 1] = r.rx_byte;
         if (offset + 5 <= total) crc = crc_step(crc, r.rx_byte);
         if (offset <= total - 1)
            add(KIND_PAYLOAD, win[9], 0, 0, 0, 0, (offset + 1 == total) ? 1'b0 : 1'b1);
         if (offset + 1 >= total) close_frame();
         else offset++;
         return;
      end
      if (fill == 0) begin
         win[0] = r.rx_byte;
         fill = 1;
      end else if (fill == 1) begin
         if ({win[0], r.rx_byte} == sync_word) begin
            win[1] = r.rx_byte;
            fill = 2;
         end else begin
            win[0] = r.rx_byte;
         end
      end else begin
         if (fill >= WINDOW_BYTES) fill = WINDOW_BYTES - 1;
         win[fill] = r.rx_byte;
         fill++;
         if (fill == WINDOW_BYTES) decide();
      end
   endfunction

   // Accepted response transfer
   function void check_result(rsp_type got);
      rsp_type exp;
      results_seen++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("ERROR: unexpected result %h", got);
         return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind || got.payload_byte !== exp.payload_byte ||
          got.command_code !== exp.command_code ||
          got.sequence_number !== exp.sequence_number ||
          got.payload_count !== exp.payload_count ||
          got.tail_word !== exp.tail_word || got.last !== exp.last) begin
         errors++;
         if (errors <= 10)
            $display("ERROR: result mismatch expected %h actual %h", exp, got);
      end
   endfunction
endclass

module sync_length_crc16_deframer_top_test;

   localparam int CYCLE_LIMIT = 400000;

   // Register byte addresses
   localparam logic [2:0] ADDR_SYNC_WORD = 3'd0;
   localparam logic [2:0] ADDR_MAX_FRAME = 3'd4;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   deframer_scoreboard sb;
   int  cycles;
   int  idle_pct;
   bit  timed_out;

   sync_length_crc16_deframer_top i_dut (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Monitor both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // Receiver stalls
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_SYNC_WORD) sb.sync_word = data[15:0];
      else sb.max_frame = data[16:0];
   endtask

   // Drive one request; returns at the falling edge after it is accepted,
   // with valid still high so the next request can follow back to back
   task automatic send(logic op, logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{operation: op, rx_byte: b};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_byte(logic [7:0] b);
      send(OP_BYTE, b);
   endtask

   // Build and send one frame; corrupt the CRC when asked
   task automatic send_frame(int payload_len, bit bad_crc);
      logic [7:0]  bytes [$];
      logic [15:0] c;
      int          n;
      n = payload_len + 8;
      bytes.push_back(sb.sync_word[15:8]);
      bytes.push_back(sb.sync_word[7:0]);
      bytes.push_back(n[15:8]);
      bytes.push_back(n[7:0]);
      for (int i = 0; i < 6 + payload_len; i++) bytes.push_back($urandom_range(255));
      c = CRC_INIT;
      foreach (bytes[i]) c = sb.crc_step(c, bytes[i]);
      if (bad_crc) c ^= 16'(1 << $urandom_range(15));
      bytes.push_back(c[15:8]);
      bytes.push_back(c[7:0]);
      bytes.push_back($urandom_range(255));
      bytes.push_back($urandom_range(255));
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   // Header with a chosen length and random filler after it
   task automatic send_header(int length_field);
      send_byte(sb.sync_word[15:8]);
      send_byte(sb.sync_word[7:0]);
      send_byte(length_field[15:8]);
      send_byte(length_field[7:0]);
      repeat (10) send_byte($urandom_range(255));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic random_phase(int n_items);
      int pick;
      int sent;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            pick = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(8);
            send_frame(pick, $urandom_range(3) == 0);
            sent += pick + 12;
         end else if (pick < 65) begin
            send_header($urandom_range(65535));
            sent += 14;
         end else if (pick < 70) begin
            send_header($urandom_range(7));
            sent += 14;
         end else if (pick < 75) begin
            send(OP_CLEAR, $urandom_range(255));
            sent++;
         end else if (pick < 85) begin
            send_byte(sb.sync_word[15:8]);
            send_byte(sb.sync_word[7:0]);
            sent += 2;
         end else begin
            send_byte($urandom_range(255));
            sent++;
         end
      end
   endtask

   initial begin
      sb = new();
      cycles = 0;
      idle_pct = 32;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset sync word, good and bad frames, clear, oversize, short length
      send_frame(0, 0);
      send_frame(3, 1);
      send_byte(8'hFF);
      send(OP_CLEAR, 8'h00);
      send_frame(1, 0);
      drain();
      csr_write(ADDR_MAX_FRAME, 32'd14);
      csr_write(ADDR_SYNC_WORD, 32'hFFFF);
      send_frame(0, 0);
      send_header(16'hFFFF);
      send_header(16'h0002);
      drain();

      // Random phases across register settings
      csr_write(ADDR_SYNC_WORD, 32'hA55A);
      csr_write(ADDR_MAX_FRAME, 32'h1FFFF);
      random_phase(400);
      drain();
      csr_write(ADDR_SYNC_WORD, $urandom_range(65535));
      csr_write(ADDR_MAX_FRAME, 32'd40);
      random_phase(400);
      drain();
      // Long stretch with no idling
      idle_pct = 0;
      csr_write(ADDR_SYNC_WORD, 32'h0000);
      csr_write(ADDR_MAX_FRAME, 32'd65541);
      random_phase(300);
      drain();
      idle_pct = 32;
      csr_write(ADDR_SYNC_WORD, 32'h7E7E);
      csr_write(ADDR_MAX_FRAME, 32'd20);
      random_phase(400);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
